@@ rtl/led_identify_sequencer_defines.svh @@
// Assertion macros shared by the LED identify sequencer RTL.
// Pure text; no dependencies.
`ifndef LED_IDENTIFY_SEQUENCER_DEFINES_SVH
`define LED_IDENTIFY_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LID_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/led_id_pkg.sv @@
// Types and constants for the LED identify sequencer.
// No dependencies; used by led_id_step and led_identify_sequencer.
package led_id_pkg;

    localparam int unsigned LED_W   = 10;
    localparam int unsigned FLASH_W = 9;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DWELL_W = 16;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned KIND_W  = 2;

    // frame kinds
    localparam logic [KIND_W-1:0] KIND_OFF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYNC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIT  = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FLASH_COUNT = 3'd0;
    localparam logic [2:0] REG_SYNC_DWELL  = 3'd1;
    localparam logic [2:0] REG_LED_DWELL   = 3'd2;
    localparam logic [2:0] REG_GROUP_SIZE  = 3'd3;
    localparam logic [2:0] REG_SYNC_LEVEL  = 3'd4;
    localparam logic [2:0] REG_LIT_LEVEL   = 3'd5;
    localparam logic [2:0] REG_LAST_LED    = 3'd6;

    typedef enum logic [2:0] {
        PH_INIT  = 3'b001,
        PH_LED   = 3'b010,
        PH_INTER = 3'b100
    } t_phase;

    typedef struct packed {
        logic [COUNT_W-1:0] initial_flash_count;
        logic [DWELL_W-1:0] sync_dwell_ms;
        logic [DWELL_W-1:0] led_dwell_ms;
        logic [LED_W-1:0]   leds_per_group;
        logic [LEVEL_W-1:0] sync_level;
        logic [LEVEL_W-1:0] lit_level;
        logic [LED_W-1:0]   last_led_index;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic [LED_W-1:0]   current_led;
        logic [FLASH_W-1:0] flash_phase;
        logic [LED_W-1:0]   lit_since_sync;
        logic [TIME_W-1:0]  last_change_ms;
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [KIND_W-1:0]  frame_kind;
        logic [LED_W-1:0]   lit_index;
        logic [LEVEL_W-1:0] level;
    } t_result;

endpackage

@@ rtl/led_identify_sequencer.sv @@
// LED identify sequencer top level: APB registers, input register, step logic,
// output register with skid entry. Depends on led_id_pkg, led_id_step and the defines header.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  input     | i_valid / o_stall       | i_now_ms
//  output    | o_valid / i_stall       | o_frame_kind, o_lit_index, o_level
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata (pready high)
//
// One transfer per cycle in each direction while that side is not stalled; an item passes
// through the input register, then the step logic into the output register.
// The step logic reads and updates the sequence state in the same cycle, so the
// state loop holds only the state register. A stalled output fills the skid entry; the input
// stalls only once the skid entry is full. Synchronous active-low reset restores
// register defaults and the start of the sequence.
`include "led_identify_sequencer_defines.svh"

module led_identify_sequencer #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [led_id_pkg::TIME_W-1:0]    i_now_ms,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [led_id_pkg::KIND_W-1:0]    o_frame_kind,
    output logic [led_id_pkg::LED_W-1:0]     o_lit_index,
    output logic [led_id_pkg::LEVEL_W-1:0]   o_level,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [4:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    led_id_pkg::t_cfg    r_cfg;
    led_id_pkg::t_state  r_state;
    led_id_pkg::t_state  n_state;
    led_id_pkg::t_result step_res;
    led_id_pkg::t_result r_out;
    led_id_pkg::t_result r_skid;
    logic                            r_in_valid;
    logic [led_id_pkg::TIME_W-1:0]   r_now;
    logic [2:0]                      reg_index;
    logic                            cfg_write;
    logic                            in_accept;
    logic                            fire;
    logic                            push;
    logic                            pop;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_flash_count <= 8'd3;
            r_cfg.sync_dwell_ms       <= 16'd200;
            r_cfg.led_dwell_ms        <= 16'd200;
            r_cfg.leds_per_group      <= 10'd10;
            r_cfg.sync_level          <= 8'd40;
            r_cfg.lit_level           <= 8'd255;
            r_cfg.last_led_index      <= 10'd999;
        end else if (cfg_write) begin
            case (reg_index)
                led_id_pkg::REG_FLASH_COUNT: r_cfg.initial_flash_count <= pwdata[7:0];
                led_id_pkg::REG_SYNC_DWELL:  r_cfg.sync_dwell_ms       <= pwdata[15:0];
                led_id_pkg::REG_LED_DWELL:   r_cfg.led_dwell_ms        <= pwdata[15:0];
                led_id_pkg::REG_GROUP_SIZE:  r_cfg.leds_per_group      <= pwdata[9:0];
                led_id_pkg::REG_SYNC_LEVEL:  r_cfg.sync_level          <= pwdata[7:0];
                led_id_pkg::REG_LIT_LEVEL:   r_cfg.lit_level           <= pwdata[7:0];
                led_id_pkg::REG_LAST_LED:    r_cfg.last_led_index      <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            led_id_pkg::REG_FLASH_COUNT: prdata = 32'(r_cfg.initial_flash_count);
            led_id_pkg::REG_SYNC_DWELL:  prdata = 32'(r_cfg.sync_dwell_ms);
            led_id_pkg::REG_LED_DWELL:   prdata = 32'(r_cfg.led_dwell_ms);
            led_id_pkg::REG_GROUP_SIZE:  prdata = 32'(r_cfg.leds_per_group);
            led_id_pkg::REG_SYNC_LEVEL:  prdata = 32'(r_cfg.sync_level);
            led_id_pkg::REG_LIT_LEVEL:   prdata = 32'(r_cfg.lit_level);
            led_id_pkg::REG_LAST_LED:    prdata = 32'(r_cfg.last_led_index);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    assign fire      = r_in_valid && !r_skid.valid;
    assign o_stall   = r_in_valid && r_skid.valid;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_now <= i_now_ms;
        end
    end

    // ---------------- step ----------------
    led_id_step #(
        .MAX_LEDS (MAX_LEDS)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_now_ms (r_now),
        .o_state  (n_state),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= led_id_pkg::PH_INIT;
            r_state.current_led    <= '0;
            r_state.flash_phase    <= '0;
            r_state.lit_since_sync <= '0;
            r_state.last_change_ms <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // ---------------- output register + skid ----------------
    assign push = fire && step_res.valid;
    assign pop  = r_out.valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid  <= 1'b0;
            r_skid.valid <= 1'b0;
        end else if (!r_out.valid || pop) begin
            // skid full implies no push this cycle
            if (r_skid.valid) begin
                r_out        <= r_skid;
                r_skid.valid <= 1'b0;
            end else if (push) begin
                r_out <= step_res;
            end else begin
                r_out.valid <= 1'b0;
            end
        end else if (push) begin
            r_skid <= step_res;
        end
    end

    assign o_valid      = r_out.valid;
    assign o_frame_kind = r_out.frame_kind;
    assign o_lit_index  = r_out.lit_index;
    assign o_level      = r_out.level;

    // ---------------- assertions ----------------
    `LID_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n,
        r_skid.valid, r_out.valid, "skid entry holds data while output register is empty")
    `LID_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n,
        push, o_valid, "result pushed but no output presented next cycle")
    `LID_ASSERT_NOW(a_kind_legal, i_clk, i_rst_n,
        o_valid,
        (o_frame_kind == led_id_pkg::KIND_OFF) || (o_frame_kind == led_id_pkg::KIND_SYNC)
            || (o_frame_kind == led_id_pkg::KIND_LIT),
        "illegal frame kind")
    `LID_ASSERT_NOW(a_index_only_lit, i_clk, i_rst_n,
        o_valid && (o_frame_kind != led_id_pkg::KIND_LIT), o_lit_index == '0,
        "lit index set on a whole-strip frame")
    `LID_ASSERT_NOW(a_off_dark, i_clk, i_rst_n,
        o_valid && (o_frame_kind == led_id_pkg::KIND_OFF), o_level == '0,
        "off frame with nonzero level")

endmodule

@@ rtl/led_id_step.sv @@
// One sequencer step: next state and optional frame from a timestamp.
// Depends on led_id_pkg.
module led_id_step #(
    parameter int unsigned MAX_LEDS = 1024
) (
    input  led_id_pkg::t_cfg              i_cfg,
    input  led_id_pkg::t_state            i_state,
    input  logic [led_id_pkg::TIME_W-1:0] i_now_ms,
    output led_id_pkg::t_state            o_state,
    output led_id_pkg::t_result           o_result
);

    localparam int unsigned LAST_CAP = MAX_LEDS - 1;

    logic [led_id_pkg::LED_W-1:0]   end_index;
    logic [led_id_pkg::TIME_W-1:0]  delta;
    logic                           went_back;
    logic                           sync_elapsed;
    logic                           led_elapsed;
    logic [led_id_pkg::LED_W:0]     next_led;
    logic [led_id_pkg::LED_W-1:0]   lit_inc;
    logic [led_id_pkg::FLASH_W-1:0] flash_limit;
    led_id_pkg::t_result            cur_frame;
    led_id_pkg::t_result            sync_frame;
    led_id_pkg::t_result            off_frame;

    always_comb begin
        if (32'(i_cfg.last_led_index) < LAST_CAP) begin
            end_index = i_cfg.last_led_index;
        end else begin
            end_index = led_id_pkg::LED_W'(LAST_CAP);
        end
    end

    // a timestamp behind the last change counts as elapsed
    assign went_back    = i_now_ms < i_state.last_change_ms;
    assign delta        = i_now_ms - i_state.last_change_ms;
    assign sync_elapsed = went_back || (delta > 32'(i_cfg.sync_dwell_ms));
    assign led_elapsed  = went_back || (delta > 32'(i_cfg.led_dwell_ms));

    assign next_led    = {1'b0, i_state.current_led} + 11'd1;
    assign lit_inc     = i_state.lit_since_sync + 10'd1;
    assign flash_limit = {i_cfg.initial_flash_count, 1'b0};

    assign sync_frame = '{valid: 1'b1, frame_kind: led_id_pkg::KIND_SYNC,
                          lit_index: '0, level: i_cfg.sync_level};
    assign off_frame  = '{valid: 1'b1, frame_kind: led_id_pkg::KIND_OFF,
                          lit_index: '0, level: '0};

    // frame for the LED held in current_led; off once it lies past the end
    always_comb begin
        if (i_state.current_led <= end_index) begin
            cur_frame = '{valid: 1'b1, frame_kind: led_id_pkg::KIND_LIT,
                          lit_index: i_state.current_led, level: i_cfg.lit_level};
        end else begin
            cur_frame = off_frame;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_state.phase)
            led_id_pkg::PH_INIT: begin
                if (sync_elapsed) begin
                    o_state.last_change_ms = i_now_ms;
                    if (i_state.flash_phase < flash_limit) begin
                        o_result = i_state.flash_phase[0] ? off_frame : sync_frame;
                        o_state.flash_phase = i_state.flash_phase + 9'd1;
                    end else begin
                        o_state.flash_phase    = '0;
                        o_state.lit_since_sync = '0;
                        o_state.phase          = led_id_pkg::PH_LED;
                        o_result               = cur_frame;
                    end
                end
            end
            led_id_pkg::PH_LED: begin
                if (led_elapsed) begin
                    o_state.last_change_ms = i_now_ms;
                    if (next_led > {1'b0, end_index}) begin
                        o_state.current_led    = '0;
                        o_state.flash_phase    = '0;
                        o_state.lit_since_sync = '0;
                        o_state.phase          = led_id_pkg::PH_INIT;
                        o_result               = off_frame;
                    end else begin
                        o_state.current_led = next_led[led_id_pkg::LED_W-1:0];
                        if (lit_inc >= i_cfg.leds_per_group) begin
                            o_state.lit_since_sync = '0;
                            o_state.phase          = led_id_pkg::PH_INTER;
                            o_state.flash_phase    = 9'd1;
                            o_result               = sync_frame;
                        end else begin
                            // next LED is within range here, so always lit
                            o_state.lit_since_sync = lit_inc;
                            o_result = '{valid: 1'b1, frame_kind: led_id_pkg::KIND_LIT,
                                         lit_index: next_led[led_id_pkg::LED_W-1:0],
                                         level: i_cfg.lit_level};
                        end
                    end
                end
            end
            led_id_pkg::PH_INTER: begin
                if (sync_elapsed) begin
                    o_state.last_change_ms = i_now_ms;
                    if (i_state.flash_phase < 9'd2) begin
                        o_result = i_state.flash_phase[0] ? off_frame : sync_frame;
                        o_state.flash_phase = i_state.flash_phase + 9'd1;
                    end else begin
                        o_state.phase = led_id_pkg::PH_LED;
                        o_result      = cur_frame;
                    end
                end
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

@@ tb/sv/tb_led_identify_sequencer.sv @@
// Self-checking testbench for led_identify_sequencer: directed timestamp table, then
// randomized register settings and tick streams, checked against an in-bench predictor.
// Depends on led_id_pkg and the led_identify_sequencer RTL.
module tb_led_identify_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 3;
    localparam int SETTLE_CYCLES   = 6;       // pipeline drain plus margin
    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 10;
    localparam int TICKS_PER_PHASE = 125;

    typedef struct packed {
        logic [led_id_pkg::KIND_W-1:0]  kind;
        logic [led_id_pkg::LED_W-1:0]   idx;
        logic [led_id_pkg::LEVEL_W-1:0] lvl;
    } t_frame;

    typedef enum logic [0:0] {ROW_TICK, ROW_REG} t_row_op;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FRAME} t_row_chk;

    typedef struct packed {
        t_row_op     op;
        logic [2:0]  reg_idx;
        logic [31:0] value;       // timestamp for a tick row, register data otherwise
        t_row_chk    chk;
        t_frame      frame;
    } t_row;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_stall;
    logic [led_id_pkg::TIME_W-1:0]        i_now_ms;
    logic                                 o_valid;
    logic                                 i_stall;
    logic [led_id_pkg::KIND_W-1:0]        o_frame_kind;
    logic [led_id_pkg::LED_W-1:0]         o_lit_index;
    logic [led_id_pkg::LEVEL_W-1:0]       o_level;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [4:0]                           paddr;
    logic [31:0]                          pwdata;
    logic [31:0]                          prdata;
    logic                                 pready;

    // predictor copy of the registers and the sequence state
    led_id_pkg::t_cfg                     cfg_m;
    led_id_pkg::t_phase                   seq_phase;
    logic [led_id_pkg::LED_W-1:0]         seq_led;
    logic [led_id_pkg::FLASH_W-1:0]       seq_flash;
    logic [led_id_pkg::LED_W-1:0]         seq_lit_count;
    logic [led_id_pkg::TIME_W-1:0]        seq_last_ms;

    t_frame                               frames_due[$];
    t_row                                 dir_rows[$];
    logic [led_id_pkg::TIME_W-1:0]        tick_ms;
    int                                   mismatches = 0;
    int                                   frames_checked = 0;
    int                                   ticks_sent = 0;
    int                                   regs_written = 0;
    int                                   cycles = 0;

    led_identify_sequencer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_now_ms     (i_now_ms),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_kind (o_frame_kind),
        .o_lit_index  (o_lit_index),
        .o_level      (o_level),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles, %0d frames outstanding",
                     cycles, frames_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // A timestamp behind the last change counts as elapsed.
    function automatic bit dwell_over(input logic [led_id_pkg::TIME_W-1:0] now,
                                      input logic [led_id_pkg::DWELL_W-1:0] dwell);
        return (now < seq_last_ms) || ((now - seq_last_ms) > 32'(dwell));
    endfunction

    function automatic t_frame led_frame();
        if (seq_led <= cfg_m.last_led_index)
            return '{led_id_pkg::KIND_LIT, seq_led, cfg_m.lit_level};
        return '{led_id_pkg::KIND_OFF, 0, 0};     // LED index past the end of the strip
    endfunction

    function automatic bit advance_sequence(input logic [led_id_pkg::TIME_W-1:0] now,
                                            output t_frame f);
        logic [led_id_pkg::LED_W:0] next_led;
        f = '{led_id_pkg::KIND_OFF, 0, 0};
        case (seq_phase)
            led_id_pkg::PH_INIT: begin
                if (!dwell_over(now, cfg_m.sync_dwell_ms))
                    return 1'b0;
                seq_last_ms = now;
                if (int'(seq_flash) < 2 * int'(cfg_m.initial_flash_count)) begin
                    if (!seq_flash[0])
                        f = '{led_id_pkg::KIND_SYNC, 0, cfg_m.sync_level};
                    seq_flash = seq_flash + 1'b1;
                end else begin
                    seq_flash     = '0;
                    seq_lit_count = '0;
                    seq_phase     = led_id_pkg::PH_LED;
                    f             = led_frame();
                end
                return 1'b1;
            end
            led_id_pkg::PH_LED: begin
                if (!dwell_over(now, cfg_m.led_dwell_ms))
                    return 1'b0;
                seq_last_ms   = now;
                next_led      = {1'b0, seq_led} + 1'b1;
                seq_lit_count = seq_lit_count + 1'b1;
                if (next_led > cfg_m.last_led_index) begin
                    seq_led       = '0;
                    seq_flash     = '0;
                    seq_lit_count = '0;
                    seq_phase     = led_id_pkg::PH_INIT;
                end else begin
                    seq_led = next_led[led_id_pkg::LED_W-1:0];
                    if (seq_lit_count >= cfg_m.leds_per_group) begin
                        seq_lit_count = '0;
                        seq_phase     = led_id_pkg::PH_INTER;
                        seq_flash     = 1;
                        f             = '{led_id_pkg::KIND_SYNC, 0, cfg_m.sync_level};
                    end else begin
                        f = led_frame();
                    end
                end
                return 1'b1;
            end
            led_id_pkg::PH_INTER: begin
                if (!dwell_over(now, cfg_m.sync_dwell_ms))
                    return 1'b0;
                seq_last_ms = now;
                if (seq_flash < 2) begin
                    if (!seq_flash[0])
                        f = '{led_id_pkg::KIND_SYNC, 0, cfg_m.sync_level};
                    seq_flash = seq_flash + 1'b1;
                end else begin
                    seq_phase = led_id_pkg::PH_LED;
                    f         = led_frame();
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_setting(input int unsigned usual_hi,
                                                 input int unsigned full_hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(0, usual_hi);
        if (r < 75)
            return 0;
        if (r < 85)
            return full_hi;
        return $urandom_range(0, full_hi);
    endfunction

    // Mostly steps near the dwell time, with backward jumps and random leaps.
    function automatic logic [led_id_pkg::TIME_W-1:0] next_stamp(
            input logic [led_id_pkg::TIME_W-1:0] prev);
        int unsigned span;
        int r;
        span = (cfg_m.sync_dwell_ms > cfg_m.led_dwell_ms) ? cfg_m.sync_dwell_ms
                                                          : cfg_m.led_dwell_ms;
        r = $urandom_range(0, 99);
        if (r < 70)
            return prev + $urandom_range(0, span + 2);
        if (r < 82)
            return prev + span + $urandom_range(0, 1);
        if (r < 92)
            return prev - $urandom_range(1, 1000);
        return $urandom();
    endfunction

    function automatic t_row tick_row(input logic [31:0] now, input t_row_chk chk,
                                      input t_frame fr);
        return '{ROW_TICK, 3'd0, now, chk, fr};
    endfunction

    function automatic t_row reg_row(input logic [2:0] idx, input logic [31:0] val);
        return '{ROW_REG, idx, val, CHK_MODEL, '0};
    endfunction

    task automatic send_tick(input logic [led_id_pkg::TIME_W-1:0] now, input t_row_chk chk,
                             input t_frame typed, input bit quiet);
        int     gap;
        t_frame f;
        bit     has;
        gap = pick_gap(quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
        has = advance_sequence(now, f);
        ticks_sent++;
        if (chk == CHK_FRAME)
            frames_due.push_back(typed);
        else if (chk == CHK_MODEL && has)
            frames_due.push_back(f);
    endtask

    // Registers change only with the pipeline empty.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            led_id_pkg::REG_FLASH_COUNT:
                cfg_m.initial_flash_count = val[led_id_pkg::COUNT_W-1:0];
            led_id_pkg::REG_SYNC_DWELL:  cfg_m.sync_dwell_ms  = val[led_id_pkg::DWELL_W-1:0];
            led_id_pkg::REG_LED_DWELL:   cfg_m.led_dwell_ms   = val[led_id_pkg::DWELL_W-1:0];
            led_id_pkg::REG_GROUP_SIZE:  cfg_m.leds_per_group = val[led_id_pkg::LED_W-1:0];
            led_id_pkg::REG_SYNC_LEVEL:  cfg_m.sync_level     = val[led_id_pkg::LEVEL_W-1:0];
            led_id_pkg::REG_LIT_LEVEL:   cfg_m.lit_level      = val[led_id_pkg::LEVEL_W-1:0];
            led_id_pkg::REG_LAST_LED:    cfg_m.last_led_index = val[led_id_pkg::LED_W-1:0];
            default: ;
        endcase
        regs_written++;
        @(posedge i_clk);
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall, frame checker
    // ------------------------------------------------------------------
    initial begin
        int r;
        int len;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                i_stall <= 1'b0;
                len = $urandom_range(100, 300);
            end else if (r < 55) begin
                i_stall <= 1'b0;
                len = $urandom_range(1, 6);
            end else if (r < 92) begin
                i_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else begin
                i_stall <= 1'b1;
                len = $urandom_range(8, 40);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (frames_due.size() == 0) begin
                $display("%0t: frame with none expected: kind %0h index %0h level %0h",
                         $time, o_frame_kind, o_lit_index, o_level);
                mismatches++;
            end else begin
                want = frames_due.pop_front();
                frames_checked++;
                check_field("frame_kind", want.kind, o_frame_kind);
                check_field("lit_index", want.idx, o_lit_index);
                check_field("level", want.lvl, o_level);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_row row;
        bit   quiet;
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_now_ms = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        cfg_m         = '{8'd3, 16'd200, 16'd200, 10'd10, 8'd40, 8'd255, 10'd999};
        seq_phase     = led_id_pkg::PH_INIT;
        seq_led       = '0;
        seq_flash     = '0;
        seq_lit_count = '0;
        seq_last_ms   = '0;

        // defaults after reset: three flashes, 200 ms dwell, strict greater-than
        dir_rows.push_back(tick_row(32'd0,         CHK_NONE,  '0));
        dir_rows.push_back(tick_row(32'd200,       CHK_NONE,  '0));
        dir_rows.push_back(tick_row(32'd201,       CHK_FRAME, '{led_id_pkg::KIND_SYNC, 0, 40}));
        dir_rows.push_back(tick_row(32'd256,       CHK_NONE,  '0));
        dir_rows.push_back(tick_row(32'hFFFF_FFFF, CHK_FRAME, '{led_id_pkg::KIND_OFF, 0, 0}));
        // time going backwards counts as elapsed
        dir_rows.push_back(tick_row(32'd0,         CHK_FRAME, '{led_id_pkg::KIND_SYNC, 0, 40}));
        dir_rows.push_back(tick_row(32'd401,       CHK_FRAME, '{led_id_pkg::KIND_OFF, 0, 0}));
        dir_rows.push_back(tick_row(32'd602,       CHK_FRAME, '{led_id_pkg::KIND_SYNC, 0, 40}));
        dir_rows.push_back(tick_row(32'd803,       CHK_FRAME, '{led_id_pkg::KIND_OFF, 0, 0}));
        dir_rows.push_back(tick_row(32'd1004,      CHK_FRAME, '{led_id_pkg::KIND_LIT, 0, 255}));
        dir_rows.push_back(tick_row(32'd1205,      CHK_FRAME, '{led_id_pkg::KIND_LIT, 1, 255}));
        // group of one: inter-group sync, then shrink the strip under the current LED
        dir_rows.push_back(reg_row(led_id_pkg::REG_SYNC_DWELL, 0));
        dir_rows.push_back(reg_row(led_id_pkg::REG_LED_DWELL, 0));
        dir_rows.push_back(reg_row(led_id_pkg::REG_GROUP_SIZE, 1));
        dir_rows.push_back(tick_row(32'd1206,      CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'd1207,      CHK_MODEL, '0));
        dir_rows.push_back(reg_row(led_id_pkg::REG_LAST_LED, 1));
        dir_rows.push_back(tick_row(32'd1208,      CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'd1209,      CHK_MODEL, '0));
        // no start flashes, zero group size, dark levels
        dir_rows.push_back(reg_row(led_id_pkg::REG_FLASH_COUNT, 0));
        dir_rows.push_back(reg_row(led_id_pkg::REG_SYNC_LEVEL, 0));
        dir_rows.push_back(reg_row(led_id_pkg::REG_LIT_LEVEL, 0));
        dir_rows.push_back(reg_row(led_id_pkg::REG_GROUP_SIZE, 0));
        dir_rows.push_back(tick_row(32'd1210,      CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'd1211,      CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'd1212,      CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'd1213,      CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'd1213,      CHK_MODEL, '0));
        // register maxima
        dir_rows.push_back(reg_row(led_id_pkg::REG_LAST_LED, 1023));
        dir_rows.push_back(reg_row(led_id_pkg::REG_SYNC_DWELL, 65535));
        dir_rows.push_back(reg_row(led_id_pkg::REG_LED_DWELL, 65535));
        dir_rows.push_back(reg_row(led_id_pkg::REG_FLASH_COUNT, 255));
        dir_rows.push_back(reg_row(led_id_pkg::REG_SYNC_LEVEL, 255));
        dir_rows.push_back(reg_row(led_id_pkg::REG_LIT_LEVEL, 255));
        dir_rows.push_back(reg_row(led_id_pkg::REG_GROUP_SIZE, 1023));
        dir_rows.push_back(tick_row(32'd66749,     CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'd132284,    CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'hFFFF_FFFF, CHK_MODEL, '0));
        dir_rows.push_back(tick_row(32'h8000_0000, CHK_MODEL, '0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.op == ROW_REG) begin
                wait_idle();
                reg_write(row.reg_idx, row.value);
            end else begin
                send_tick(row.value, row.chk, row.frame, 1'b0);
            end
        end

        tick_ms = 32'h8000_0000;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            reg_write(led_id_pkg::REG_FLASH_COUNT, pick_setting(3, 255));
            reg_write(led_id_pkg::REG_SYNC_DWELL,  pick_setting(6, 65535));
            reg_write(led_id_pkg::REG_LED_DWELL,   pick_setting(6, 65535));
            reg_write(led_id_pkg::REG_GROUP_SIZE,  pick_setting(5, 1023));
            reg_write(led_id_pkg::REG_SYNC_LEVEL,  pick_setting(255, 255));
            reg_write(led_id_pkg::REG_LIT_LEVEL,   pick_setting(255, 255));
            reg_write(led_id_pkg::REG_LAST_LED,    pick_setting(30, 1023));
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < TICKS_PER_PHASE; k++) begin
                tick_ms = next_stamp(tick_ms);
                send_tick(tick_ms, CHK_MODEL, '0, quiet);
            end
        end

        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d frames from %0d timestamp transfers and %0d register writes,",
                 frames_checked, ticks_sent, regs_written);
        $display("covering directed edge cases and %0d randomized register settings.",
                 RANDOM_PHASES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
